FILE: design/fyd_pkg.sv
// ----------------------------------------------------------------------------
// fyd_pkg
// Types and constants shared by the frequent-yielder detector modules.
// ----------------------------------------------------------------------------
package fyd_pkg;

  localparam int TIME_W     = 64;
  localparam int TOTAL_W    = 32;
  localparam int THR_W      = 16;
  localparam int CNT8_W     = 8;
  localparam int MASK_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Scaled threshold: 64-bit elapsed time times a 16-bit threshold.
  localparam int PROD_W     = TIME_W + THR_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_WINDOW_LEN   = 3'd0;
  localparam cfg_idx_t CFG_GRACE_LEN    = 3'd1;
  localparam cfg_idx_t CFG_YIELD_THR    = 3'd2;
  localparam cfg_idx_t CFG_YIELD_THR_PL = 3'd3;
  localparam cfg_idx_t CFG_SLEEP_THR    = 3'd4;
  localparam cfg_idx_t CFG_MIN_WINDOWS  = 3'd5;
  localparam cfg_idx_t CFG_TASK_THR     = 3'd6;
  localparam cfg_idx_t CFG_PIPE_MASK    = 3'd7;

  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_YIELD  = 1'b1;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_len;
    logic [TOTAL_W-1:0] grace_len;
    logic [THR_W-1:0]   yield_thr_default;
    logic [THR_W-1:0]   yield_thr_pipeline;
    logic [THR_W-1:0]   sleep_thr;
    logic [CNT8_W-1:0]  min_windows;
    logic [CNT8_W-1:0]  task_yield_thr;
    logic [MASK_W-1:0]  pipeline_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_delta;
    logic check;
    logic mul;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_window;
    logic late;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: design/fyd_item_if.sv
// ----------------------------------------------------------------------------
// fyd_item_if
// Input channel: one window check or yield event per beat.
// ----------------------------------------------------------------------------
interface fyd_item_if #(
  parameter int REASON_WIDTH = 32
) ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [63:0]             now_ns;
  logic [REASON_WIDTH-1:0] cluster_reason;
  logic [7:0]              task_yield_count;
  logic                    eligible;

  modport source (
    output valid, op, now_ns, cluster_reason, task_yield_count, eligible,
    input  ready
  );

  modport sink (
    input  valid, op, now_ns, cluster_reason, task_yield_count, eligible,
    output ready
  );
endinterface

FILE: design/fyd_result_if.sv
// ----------------------------------------------------------------------------
// fyd_result_if
// Result channel: one decision per accepted item.
// ----------------------------------------------------------------------------
interface fyd_result_if ();
  logic       valid;
  logic       ready;
  logic       count_inc;
  logic       inject_sleep;
  logic       window_closed;
  logic [7:0] yield_run;

  modport source (
    output valid, count_inc, inject_sleep, window_closed, yield_run,
    input  ready
  );

  modport sink (
    input  valid, count_inc, inject_sleep, window_closed, yield_run,
    output ready
  );
endinterface

FILE: design/frequent_yielder_detector.sv
// ----------------------------------------------------------------------------
// frequent_yielder_detector
// Tracks system-wide yielding over time windows and asks for injected sleeps.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A yield event, or a window check that finds
// the window still open or closes it on time, goes through the delta, check
// and finish states before the next item can be accepted; a check closing
// the window later than window_len + grace_len also goes through the multiply
// state and the 80-step restoring divider that scales both thresholds by
// elapsed/window (yield and sleep lanes side by side). Results wait in an
// output register, so a new item is accepted while the last result is held.
module frequent_yielder_detector #(
  parameter int REASON_WIDTH  = 32,
  parameter int NO_REASON_BIT = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  fyd_item_if.sink                       item,
  fyd_result_if.source                   result,
  input  logic                           cfg_we,
  input  fyd_pkg::cfg_idx_t              cfg_idx,
  input  logic [fyd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fyd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // Register bank: the user must write it only while no item is in flight; the bank does not enforce this.
  fyd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Sequencer: raises ready only when idle, then walks the item through.
  fyd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: window state, divider lanes and the result register.
  fyd_dp #(
    .REASON_WIDTH  (REASON_WIDTH),
    .NO_REASON_BIT (NO_REASON_BIT)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .st                    (st),
    .item_op               (item.op),
    .item_now_ns           (item.now_ns),
    .item_cluster_reason   (item.cluster_reason),
    .item_task_yield_count (item.task_yield_count),
    .item_eligible         (item.eligible),
    .res_valid             (result.valid),
    .res_ready             (result.ready),
    .res_count_inc         (result.count_inc),
    .res_inject_sleep      (result.inject_sleep),
    .res_window_closed     (result.window_closed),
    .res_yield_run         (result.yield_run)
  );

`ifndef NO_ASSERTIONS
  // Drop ready after every accepted beat: one item in flight at a time.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item accepted while another is in flight");

  // A closing window check never asks for a count or a sleep.
  a_close_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.window_closed && (result.count_inc || result.inject_sleep)))
    else $error("window close combined with a yield decision");

  // Injecting a sleep and incrementing the task count are alternatives.
  a_yield_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.count_inc && result.inject_sleep))
    else $error("count_inc and inject_sleep both set");
`endif

endmodule

FILE: design/fyd_cfg.sv
// ----------------------------------------------------------------------------
// fyd_cfg
// Configuration register bank, written one register per beat.
// ----------------------------------------------------------------------------
module fyd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  fyd_pkg::cfg_idx_t           cfg_idx,
  input  logic [fyd_pkg::CFG_DATA_W-1:0] cfg_data,
  output fyd_pkg::cfg_t               cfg
);
  import fyd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len         <= TOTAL_W'(16000000);
      cfg.grace_len          <= '0;
      cfg.yield_thr_default  <= '0;
      cfg.yield_thr_pipeline <= '0;
      cfg.sleep_thr          <= '0;
      cfg.min_windows        <= '0;
      cfg.task_yield_thr     <= '0;
      cfg.pipeline_mask      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WINDOW_LEN:   cfg.window_len         <= cfg_data[TOTAL_W-1:0];
        CFG_GRACE_LEN:    cfg.grace_len          <= cfg_data[TOTAL_W-1:0];
        CFG_YIELD_THR:    cfg.yield_thr_default  <= cfg_data[THR_W-1:0];
        CFG_YIELD_THR_PL: cfg.yield_thr_pipeline <= cfg_data[THR_W-1:0];
        CFG_SLEEP_THR:    cfg.sleep_thr          <= cfg_data[THR_W-1:0];
        CFG_MIN_WINDOWS:  cfg.min_windows        <= cfg_data[CNT8_W-1:0];
        CFG_TASK_THR:     cfg.task_yield_thr     <= cfg_data[CNT8_W-1:0];
        CFG_PIPE_MASK:    cfg.pipeline_mask      <= cfg_data[MASK_W-1:0];
      endcase
    end
  end

endmodule

FILE: design/fyd_ctrl.sv
// ----------------------------------------------------------------------------
// fyd_ctrl
// Sequencer: steps one item through delta, check, scaling and commit.
// ----------------------------------------------------------------------------
module fyd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fyd_pkg::status_t st,
  output fyd_pkg::cmd_t    cmd
);
  import fyd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.calc_delta = 1'b1;
        state_next     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        // late close needs scaled thresholds
        if (st.is_window && st.late) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register can take the beat
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/fyd_dp.sv
// ----------------------------------------------------------------------------
// fyd_dp
// Datapath: window state, threshold scaling by a two-lane restoring divider,
// and the result register.
// ----------------------------------------------------------------------------
module fyd_dp #(
  parameter int REASON_WIDTH  = 32,
  parameter int NO_REASON_BIT = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fyd_pkg::cfg_t           cfg,
  input  fyd_pkg::cmd_t           cmd,
  output fyd_pkg::status_t        st,
  input  logic                    item_op,
  input  logic [63:0]             item_now_ns,
  input  logic [REASON_WIDTH-1:0] item_cluster_reason,
  input  logic [7:0]              item_task_yield_count,
  input  logic                    item_eligible,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    res_count_inc,
  output logic                    res_inject_sleep,
  output logic                    res_window_closed,
  output logic [7:0]              res_yield_run
);
  import fyd_pkg::*;

  localparam logic [REASON_WIDTH-1:0] REASON_KEEP =
    ~(REASON_WIDTH'(1) << NO_REASON_BIT);

  // captured item
  logic                    op_q;
  logic [TIME_W-1:0]       now_q;
  logic [REASON_WIDTH-1:0] reason_q;
  logic [CNT8_W-1:0]       tcount_q;
  logic                    elig_q;

  // window state
  logic [TIME_W-1:0]  window_start;
  logic [TOTAL_W-1:0] yield_total;
  logic [TOTAL_W-1:0] sleep_total;
  logic [CNT8_W-1:0]  run_windows;

  // per-item working registers
  logic [TIME_W-1:0]    delta_q;
  logic                 close_q;
  logic                 late_q;
  logic [THR_W-1:0]     thr_q;
  logic [PROD_W-1:0]    a_y;
  logic [PROD_W-1:0]    a_s;
  logic [TOTAL_W-1:0]   rem_y;
  logic [TOTAL_W-1:0]   rem_s;
  logic [DIV_CNT_W-1:0] cnt;

  logic [TOTAL_W-1:0] w_eff;
  logic [TOTAL_W:0]   late_limit;
  logic [MASK_W-1:0]  reason32;
  logic [THR_W-1:0]   thr_c;
  logic               closes_c;
  logic               late_c;

  logic [TOTAL_W:0]   ty;
  logic [TOTAL_W:0]   ts;
  logic               ge_y;
  logic               ge_s;
  logic [TOTAL_W-1:0] rem_y_next;
  logic [TOTAL_W-1:0] rem_s_next;

  logic [PROD_W-1:0]  wake_t;
  logic [PROD_W-1:0]  sleep_half;
  logic               yielding;
  logic               no_reason;

  logic [TIME_W-1:0]  window_start_next;
  logic [TOTAL_W-1:0] yield_total_next;
  logic [TOTAL_W-1:0] sleep_total_next;
  logic [CNT8_W-1:0]  run_windows_next;
  logic               ci_next;
  logic               inj_next;
  logic               cl_next;

  generate
    if (REASON_WIDTH >= MASK_W) begin : g_rs_wide
      assign reason32 = reason_q[MASK_W-1:0];
    end else begin : g_rs_narrow
      assign reason32 = {{(MASK_W-REASON_WIDTH){1'b0}}, reason_q};
    end
  endgenerate

  // a zero window length behaves as one
  assign w_eff      = (cfg.window_len == '0) ? TOTAL_W'(1) : cfg.window_len;
  assign late_limit = {1'b0, w_eff} + {1'b0, cfg.grace_len};
  assign closes_c   = delta_q > TIME_W'(w_eff);
  assign late_c     = delta_q > TIME_W'(late_limit);
  assign thr_c      = ((reason32 & cfg.pipeline_mask) != '0) ? cfg.yield_thr_pipeline
                                                             : cfg.yield_thr_default;

  assign st.is_window = (op_q == OP_WINDOW) && closes_c;
  assign st.late      = late_c;
  assign st.div_last  = cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign st.out_free  = !res_valid || res_ready;

  // one quotient bit per lane per cycle
  always_comb begin
    ty         = {rem_y, a_y[PROD_W-1]};
    ts         = {rem_s, a_s[PROD_W-1]};
    ge_y       = ty >= {1'b0, w_eff};
    ge_s       = ts >= {1'b0, w_eff};
    rem_y_next = ge_y ? TOTAL_W'(ty - {1'b0, w_eff}) : ty[TOTAL_W-1:0];
    rem_s_next = ge_s ? TOTAL_W'(ts - {1'b0, w_eff}) : ts[TOTAL_W-1:0];
  end

  always_comb begin
    wake_t     = late_q ? a_y : PROD_W'(thr_q);
    sleep_half = (late_q ? a_s : PROD_W'(cfg.sleep_thr)) >> 1;
    yielding   = (PROD_W'(yield_total) >= wake_t) || (PROD_W'(sleep_total) >= sleep_half);
    no_reason  = (reason_q & REASON_KEEP) == '0;

    window_start_next = window_start;
    yield_total_next  = yield_total;
    sleep_total_next  = sleep_total;
    run_windows_next  = run_windows;
    ci_next           = 1'b0;
    inj_next          = 1'b0;
    cl_next           = 1'b0;

    if (op_q == OP_WINDOW) begin
      if (close_q) begin
        if (yielding) begin
          if (run_windows < cfg.min_windows) begin
            run_windows_next = run_windows + 1'b1;
          end
        end else begin
          run_windows_next = '0;
        end
        window_start_next = now_q;
        yield_total_next  = '0;
        sleep_total_next  = '0;
        cl_next           = 1'b1;
      end
    end else if (elig_q) begin
      if (tcount_q >= cfg.task_yield_thr) begin
        yield_total_next = (yield_total == '1) ? yield_total : yield_total + 1'b1;
        if ((run_windows >= cfg.min_windows) && no_reason) begin
          inj_next         = 1'b1;
          sleep_total_next = (sleep_total == '1) ? sleep_total : sleep_total + 1'b1;
        end
      end else begin
        ci_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= item_op;
      now_q    <= item_now_ns;
      reason_q <= item_cluster_reason;
      tcount_q <= item_task_yield_count;
      elig_q   <= item_eligible;
    end
    if (cmd.calc_delta) begin
      delta_q <= now_q - window_start;
    end
    if (cmd.check) begin
      close_q <= closes_c;
      late_q  <= late_c;
      thr_q   <= thr_c;
    end
    if (cmd.mul) begin
      a_y   <= PROD_W'(delta_q) * PROD_W'(thr_q);
      a_s   <= PROD_W'(delta_q) * PROD_W'(cfg.sleep_thr);
      rem_y <= '0;
      rem_s <= '0;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      a_y   <= {a_y[PROD_W-2:0], ge_y};
      a_s   <= {a_s[PROD_W-2:0], ge_s};
      rem_y <= rem_y_next;
      rem_s <= rem_s_next;
      cnt   <= cnt + 1'b1;
    end
    if (cmd.commit) begin
      res_count_inc     <= ci_next;
      res_inject_sleep  <= inj_next;
      res_window_closed <= cl_next;
      res_yield_run     <= run_windows_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      yield_total  <= '0;
      sleep_total  <= '0;
      run_windows  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        window_start <= window_start_next;
        yield_total  <= yield_total_next;
        sleep_total  <= sleep_total_next;
        run_windows  <= run_windows_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
